/* hdl/lpc_pkg.sv */
// Shared definitions for the page cache tag and recency controller.
// Field widths, default parameters, result status codes and the
// command and status groups that join the controller and the datapath.
package lpc_pkg;

    localparam int DEF_NUM_PAGES = 16;
    localparam int DEF_ADDR_BITS = 32;

    localparam int OFF_W  = 32;
    localparam int SIZE_W = 32;
    localparam int FLEN_W = 17;
    localparam int POS_W  = 16;
    localparam int SLOT_W = 6;
    localparam int PSL_W  = 5;

    localparam logic [PSL_W-1:0] PSL_RESET = 5'd12;
    localparam logic [PSL_W-1:0] PSL_MIN   = 5'd6;
    localparam logic [PSL_W-1:0] PSL_MAX   = 5'd16;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_FILLED   = 3'd2,
        ST_FILL_ERR = 3'd3,
        ST_REFUSED  = 3'd4
    } t_status;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

/* hdl/lpc_req_if.sv */
// Request channel: lookups and fill responses with valid/ready.
// Depends on lpc_pkg for the field widths.
interface lpc_req_if;
    import lpc_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [OFF_W-1:0]  byte_offset;
    logic [SIZE_W-1:0] request_size;
    logic [FLEN_W-1:0] fill_length;
    logic              fill_error;

    modport source (output valid, action, byte_offset, request_size, fill_length,
                    fill_error, input ready);
    modport sink   (input valid, action, byte_offset, request_size, fill_length,
                    fill_error, output ready);
endinterface

/* hdl/lpc_rsp_if.sv */
// Result channel: one result beat per request, with valid/ready.
// Depends on lpc_pkg for the status type and field widths.
interface lpc_rsp_if;
    import lpc_pkg::*;

    logic              valid;
    logic              ready;
    t_status           status;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  page_base;
    logic [POS_W-1:0]  page_position;
    logic [FLEN_W-1:0] copy_bytes;
    logic              final_page;
    logic              beyond_end;

    modport source (output valid, status, slot, page_base, page_position, copy_bytes,
                    final_page, beyond_end, input ready);
    modport sink   (input valid, status, slot, page_base, page_position, copy_bytes,
                    final_page, beyond_end, output ready);
endinterface

/* hdl/lpc_cfg_if.sv */
// Configuration write channel carrying the page size register.
// Depends on lpc_pkg for the register width.
interface lpc_cfg_if;
    import lpc_pkg::*;

    logic             valid;
    logic             ready;
    logic [PSL_W-1:0] page_size_log2;

    modport source (output valid, page_size_log2, input ready);
    modport sink   (input valid, page_size_log2, output ready);
endinterface

/* hdl/lpc_ctrl.sv */
// Controller for the page cache: accepts a request beat, then commits
// the update and result once the output register is free.
// Depends on lpc_pkg.
module lpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  lpc_pkg::t_dp_sts i_sts,
    output lpc_pkg::t_ctl_cmd o_cmd
);
    import lpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.commit = (r_state == S_UPDATE) && !i_sts.out_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/lpc_dp.sv */
// Datapath for the page cache: tag and length stores, valid bits, recency
// ranks, pending fill, page size register and the result register.
// Depends on lpc_pkg and the three channel interfaces.
module lpc_dp #(
    parameter int NUM_PAGES = lpc_pkg::DEF_NUM_PAGES,
    parameter int ADDR_BITS = lpc_pkg::DEF_ADDR_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpc_pkg::t_ctl_cmd i_cmd,
    output lpc_pkg::t_dp_sts  o_sts,
    lpc_req_if.sink           i_req,
    lpc_cfg_if.sink           i_cfg,
    lpc_rsp_if.source         o_rsp
);
    import lpc_pkg::*;

    localparam int AW = (ADDR_BITS < OFF_W) ? ADDR_BITS : OFF_W;
    localparam int SW = $clog2(NUM_PAGES);
    localparam int CW = (AW > FLEN_W) ? AW : FLEN_W;

    // Configuration
    logic [PSL_W-1:0]  r_psl;
    logic [PSL_W-1:0]  psl_clamped;
    logic [FLEN_W-1:0] psize;
    logic [AW-1:0]     base_mask;

    // Per-slot state
    logic [AW-1:0]        r_base [NUM_PAGES];
    logic [FLEN_W-1:0]    r_len  [NUM_PAGES];
    logic [NUM_PAGES-1:0] r_valid;
    logic [SW-1:0]        r_rank [NUM_PAGES];

    // Pending fill
    logic              r_pend;
    logic [SW-1:0]     r_pend_slot;
    logic [AW-1:0]     r_pend_off;
    logic [SIZE_W-1:0] r_pend_size;

    // Captured request
    logic                 r_act;
    logic [AW-1:0]        r_off;
    logic [SIZE_W-1:0]    r_size;
    logic [FLEN_W-1:0]    r_flen;
    logic                 r_ferr;
    logic [NUM_PAGES-1:0] r_best;
    logic                 r_any_hit;

    // Result register
    logic              r_out_valid;
    t_status           r_status;
    logic [SLOT_W-1:0] r_slot;
    logic [OFF_W-1:0]  r_page_base;
    logic [POS_W-1:0]  r_pos;
    logic [FLEN_W-1:0] r_copy;
    logic              r_final;
    logic              r_beyond;

    // Tag compare on the incoming beat
    logic [AW-1:0]        in_off;
    logic [AW:0]          cmp_diff [NUM_PAGES];
    logic [NUM_PAGES-1:0] hit;
    logic [NUM_PAGES-1:0] best;

    // Update stage
    logic [SW-1:0]     hit_idx;
    logic [SW-1:0]     vic_idx;
    logic [SW-1:0]     sel_slot;
    logic [AW-1:0]     sel_base;
    logic [FLEN_W-1:0] sel_len;
    logic [AW-1:0]     src_off;
    logic              is_miss;
    logic              refused;
    logic [AW-1:0]     base_eff;
    logic [AW-1:0]     pos_full;
    logic [FLEN_W-1:0] pos_ext;
    logic [FLEN_W-1:0] flen_sat;
    logic              fill_beyond;
    logic [FLEN_W-1:0] min_src;
    logic [SIZE_W-1:0] min_lim;
    logic [FLEN_W-1:0] min_val;
    logic [SW-1:0]     sel_rank;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psl <= PSL_RESET;
        end else if (i_cfg.valid) begin
            r_psl <= i_cfg.page_size_log2;
        end
    end

    always_comb begin
        if (r_psl < PSL_MIN) begin
            psl_clamped = PSL_MIN;
        end else if (r_psl > PSL_MAX) begin
            psl_clamped = PSL_MAX;
        end else begin
            psl_clamped = r_psl;
        end
    end

    assign psize     = FLEN_W'(1) << psl_clamped;
    assign base_mask = ~((AW'(1) << psl_clamped) - AW'(1));

    // Each valid slot compares in parallel; among the covering slots the one
    // with the lowest rank (most recent) wins, which keeps the result one-hot.
    assign in_off = i_req.byte_offset[AW-1:0];

    always_comb begin
        for (int i = 0; i < NUM_PAGES; i++) begin
            cmp_diff[i] = {1'b0, in_off} - {1'b0, r_base[i]};
            hit[i] = r_valid[i] && !cmp_diff[i][AW] &&
                     (CW'(cmp_diff[i][AW-1:0]) < CW'(r_len[i]));
        end
        for (int i = 0; i < NUM_PAGES; i++) begin
            best[i] = hit[i];
            for (int j = 0; j < NUM_PAGES; j++) begin
                if (hit[j] && (r_rank[j] < r_rank[i])) best[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act     <= i_req.action;
            r_off     <= in_off;
            r_size    <= i_req.request_size;
            r_flen    <= i_req.fill_length;
            r_ferr    <= i_req.fill_error;
            r_best    <= best;
            r_any_hit <= |hit;
        end
    end

    always_comb begin
        hit_idx = '0;
        vic_idx = '0;
        for (int i = 0; i < NUM_PAGES; i++) begin
            if (r_best[i]) hit_idx = hit_idx | SW'(i);
            if (r_rank[i] == SW'(NUM_PAGES - 1)) vic_idx = vic_idx | SW'(i);
        end
    end

    assign is_miss  = !r_act && !r_any_hit;
    assign refused  = r_act ? !r_pend : r_pend;
    assign sel_slot = r_act ? r_pend_slot : (r_any_hit ? hit_idx : vic_idx);
    assign sel_base = r_base[sel_slot];
    assign sel_len  = r_len[sel_slot];
    assign sel_rank = r_rank[sel_slot];
    assign src_off  = r_act ? r_pend_off : r_off;
    assign base_eff = is_miss ? (r_off & base_mask) : sel_base;
    assign pos_full = src_off - base_eff;
    assign pos_ext  = {1'b0, pos_full[POS_W-1:0]};

    assign flen_sat    = (r_flen > psize) ? psize : r_flen;
    assign fill_beyond = (pos_ext >= flen_sat);

    // The page remainder is clipped to the bytes still wanted, shared by
    // the hit and the fill paths.
    assign min_src = r_act ? (flen_sat - pos_ext) : (sel_len - pos_ext);
    assign min_lim = r_act ? r_pend_size : r_size;
    assign min_val = (SIZE_W'(min_src) > min_lim) ? FLEN_W'(min_lim) : min_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pend      <= 1'b0;
            r_pend_slot <= '0;
            for (int i = 0; i < NUM_PAGES; i++) begin
                r_rank[i] <= SW'(i);
            end
        end else if (i_cmd.commit && !refused) begin
            if (!r_act) begin
                for (int i = 0; i < NUM_PAGES; i++) begin
                    if (SW'(i) == sel_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_rank[i] < sel_rank) begin
                        r_rank[i] <= r_rank[i] + SW'(1);
                    end
                end
                if (is_miss) begin
                    r_valid[sel_slot] <= 1'b0;
                    r_pend            <= 1'b1;
                    r_pend_slot       <= sel_slot;
                end
            end else begin
                r_pend            <= 1'b0;
                r_valid[sel_slot] <= !r_ferr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !refused) begin
            if (is_miss) begin
                r_base[sel_slot] <= base_eff;
                r_pend_off       <= r_off;
                r_pend_size      <= r_size;
            end
            if (r_act && !r_ferr) begin
                r_len[sel_slot] <= flen_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_slot      <= SLOT_W'(sel_slot);
            r_page_base <= OFF_W'(base_eff);
            r_pos       <= pos_full[POS_W-1:0];
            r_copy      <= '0;
            r_final     <= 1'b0;
            r_beyond    <= 1'b0;
            if (refused) begin
                r_status    <= ST_REFUSED;
                r_slot      <= '0;
                r_page_base <= '0;
                r_pos       <= '0;
            end else if (!r_act && r_any_hit) begin
                r_status <= ST_HIT;
                r_copy   <= min_val;
                r_final  <= (sel_len < psize);
            end else if (!r_act) begin
                r_status <= ST_MISS;
            end else if (r_ferr) begin
                r_status <= ST_FILL_ERR;
                r_pos    <= '0;
            end else begin
                r_status <= ST_FILLED;
                r_copy   <= fill_beyond ? '0 : min_val;
                r_final  <= (flen_sat < psize);
                r_beyond <= fill_beyond;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.slot          = r_slot;
    assign o_rsp.page_base     = r_page_base;
    assign o_rsp.page_position = r_pos;
    assign o_rsp.copy_bytes    = r_copy;
    assign o_rsp.final_page    = r_final;
    assign o_rsp.beyond_end    = r_beyond;

    assign o_sts.out_busy = r_out_valid && !o_rsp.ready;

endmodule

/* hdl/lru_page_cache_controller.sv */
// Use of the block:
// Tag and recency controller for a fully associative page cache. Requests
// arrive on i_req: action 0 is a lookup (byte offset and bytes wanted),
// action 1 the fill response for the page last missed (length or error).
// Every request beat yields exactly one result beat on o_rsp: hit, miss
// with the fill address, filled, fill error, or refused when a lookup
// comes while a fill is pending or a fill comes with none pending.
// i_cfg writes log2 of the page size (clamped to 6..16), and is always
// ready; write it only while no request is in flight.
// A request is taken while idle and its parallel tag compare is registered;
// the update and result register are written in the update state once the
// output register is free; a new request is taken only after that update.
// A finished result waits in the output register; the next request is
// still accepted, and its update stalls only while that result is held.
// Reset clears all valid bits, the pending fill and the output, ranks
// slot i as i-th most recent and sets the page size to 4096 bytes.
// Depends on lpc_pkg, the channel interfaces, lpc_ctrl and lpc_dp.
module lru_page_cache_controller #(
    parameter int NUM_PAGES = lpc_pkg::DEF_NUM_PAGES,
    parameter int ADDR_BITS = lpc_pkg::DEF_ADDR_BITS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    lpc_req_if.sink    i_req,
    lpc_cfg_if.sink    i_cfg,
    lpc_rsp_if.source  o_rsp
);
    import lpc_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_dp_sts  dp_sts;
    logic     ctl_ready;

    lpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (ctl_ready),
        .i_sts       (dp_sts),
        .o_cmd       (ctl_cmd)
    );

    assign i_req.ready = ctl_ready;

    lpc_dp #(
        .NUM_PAGES (NUM_PAGES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ctl_cmd),
        .o_sts   (dp_sts),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.accept |=> !ctl_ready)
        else $error("request taken while the previous one is still in update");

    a_commit_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.commit |=> o_rsp.valid)
        else $error("committed result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.commit |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result register overwritten while held");

    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_REFUSED) |->
            (o_rsp.slot == '0 && o_rsp.page_base == '0 && o_rsp.copy_bytes == '0))
        else $error("refused result carries data");

    a_copy_only_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_MISS || o_rsp.status == ST_FILL_ERR ||
                         o_rsp.beyond_end)) |-> (o_rsp.copy_bytes == '0))
        else $error("copy length given without page data");
`endif

endmodule

/* tb/tb_lru_page_cache_controller.sv */
// Self-checking testbench for the page cache tag and recency controller.
// Predicts each result from its own model of the slots, ranks and pending fill.
// Depends on lpc_pkg, the three channel interfaces and lru_page_cache_controller.
module tb_lru_page_cache_controller;
    import lpc_pkg::*;

    localparam int NP           = DEF_NUM_PAGES;
    localparam int RANK_W       = $clog2(NP);
    localparam int NUM_SEGMENTS = 8;
    localparam int SEG_ITEMS    = 130;
    localparam int RUN_LIMIT    = 2000000;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    typedef struct packed {
        logic              action;
        logic [OFF_W-1:0]  byte_offset;
        logic [SIZE_W-1:0] request_size;
        logic [FLEN_W-1:0] fill_length;
        logic              fill_error;
    } t_req_item;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  page_base;
        logic [POS_W-1:0]  page_position;
        logic [FLEN_W-1:0] copy_bytes;
        logic              final_page;
        logic              beyond_end;
    } t_page_result;

    typedef struct packed {
        logic [NP-1:0][OFF_W-1:0]  base;
        logic [NP-1:0][FLEN_W-1:0] len;
        logic [NP-1:0]             valid;
        logic [NP-1:0][RANK_W-1:0] rank;
        logic                      pending;
        logic [RANK_W-1:0]         pslot;
        logic [OFF_W-1:0]          poff;
        logic [SIZE_W-1:0]         psize;
    } t_cache_state;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lpc_req_if req_if();
    lpc_cfg_if cfg_if();
    lpc_rsp_if rsp_if();

    logic             req_valid = 1'b0;
    t_req_item        req_item  = '0;
    logic             rsp_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [PSL_W-1:0] cfg_value = '0;

    assign req_if.valid        = req_valid;
    assign req_if.action       = req_item.action;
    assign req_if.byte_offset  = req_item.byte_offset;
    assign req_if.request_size = req_item.request_size;
    assign req_if.fill_length  = req_item.fill_length;
    assign req_if.fill_error   = req_item.fill_error;
    assign rsp_if.ready        = rsp_ready;
    assign cfg_if.valid        = cfg_valid;
    assign cfg_if.page_size_log2 = cfg_value;

    lru_page_cache_controller u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_cache_state     cache_now;
    t_cache_state     plan_state;
    logic [PSL_W-1:0] page_size_cfg;
    t_req_item        req_backlog[$];
    t_page_result     predicted_rsp[$];
    logic [OFF_W-1:0] hot_base[8];
    logic [OFF_W-1:0] seq_next;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               accepted_reqs = 0;
    int               results_seen  = 0;
    int               fail_count    = 0;

    function automatic longint unsigned page_bytes(input logic [PSL_W-1:0] psl_raw);
        logic [PSL_W-1:0] lg;
        lg = (psl_raw < PSL_MIN) ? PSL_MIN : ((psl_raw > PSL_MAX) ? PSL_MAX : psl_raw);
        return 64'd1 << lg;
    endfunction

    function automatic t_cache_state cache_reset_state();
        t_cache_state st;
        st = '0;
        for (int i = 0; i < NP; i++)
            st.rank[i] = RANK_W'(i);
        return st;
    endfunction

    function automatic void promote_slot(inout t_cache_state st, input int s);
        logic [RANK_W-1:0] r;
        r = st.rank[s];
        for (int i = 0; i < NP; i++)
            if (st.rank[i] < r) st.rank[i] = st.rank[i] + 1'b1;
        st.rank[s] = '0;
    endfunction

    // Applies one request beat to the cache state and returns the result it causes.
    function automatic t_page_result cache_step(inout t_cache_state st, input t_req_item it,
                                                input logic [PSL_W-1:0] psl_raw);
        t_page_result    r;
        longint unsigned psz, off, base, flen, pos, cp;
        int              hit, victim, s;
        r      = '0;
        psz    = page_bytes(psl_raw);
        off    = it.byte_offset;
        hit    = -1;
        victim = 0;
        if (it.action == ACT_LOOKUP) begin
            if (st.pending) begin
                r.status = ST_REFUSED;
                return r;
            end
            // Where pages overlap after a size change, the most recent one wins.
            for (int i = 0; i < NP; i++)
                if (st.valid[i] && off >= st.base[i] &&
                    off < longint'(st.base[i]) + st.len[i] &&
                    (hit < 0 || st.rank[i] < st.rank[hit]))
                    hit = i;
            if (hit >= 0) begin
                promote_slot(st, hit);
                base = st.base[hit];
                pos  = off - base;
                cp   = st.len[hit] - pos;
                if (cp > it.request_size) cp = it.request_size;
                r.status        = ST_HIT;
                r.slot          = SLOT_W'(hit);
                r.page_base     = OFF_W'(base);
                r.page_position = POS_W'(pos);
                r.copy_bytes    = FLEN_W'(cp);
                r.final_page    = (st.len[hit] < psz);
                return r;
            end
            for (int i = 0; i < NP; i++)
                if (st.rank[i] == RANK_W'(NP - 1)) victim = i;
            base = off & ~(psz - 64'd1);
            st.base[victim]  = OFF_W'(base);
            st.len[victim]   = '0;
            st.valid[victim] = 1'b0;
            promote_slot(st, victim);
            st.pending = 1'b1;
            st.pslot   = RANK_W'(victim);
            st.poff    = it.byte_offset;
            st.psize   = it.request_size;
            r.status        = ST_MISS;
            r.slot          = SLOT_W'(victim);
            r.page_base     = OFF_W'(base);
            r.page_position = POS_W'(off - base);
            return r;
        end
        if (!st.pending) begin
            r.status = ST_REFUSED;
            return r;
        end
        s          = st.pslot;
        st.pending = 1'b0;
        base       = st.base[s];
        pos        = longint'(st.poff) - base;
        r.slot      = SLOT_W'(s);
        r.page_base = OFF_W'(base);
        if (it.fill_error) begin
            st.len[s]   = '0;
            st.valid[s] = 1'b0;
            r.status    = ST_FILL_ERR;
            return r;
        end
        flen = it.fill_length;
        if (flen > psz) flen = psz;
        st.len[s]       = FLEN_W'(flen);
        st.valid[s]     = 1'b1;
        r.status        = ST_FILLED;
        r.page_position = POS_W'(pos);
        r.final_page    = (flen < psz);
        if (longint'(st.poff) >= base + flen) begin
            r.beyond_end = 1'b1;
            return r;
        end
        cp = flen - pos;
        if (cp > st.psize) cp = st.psize;
        r.copy_bytes = FLEN_W'(cp);
        return r;
    endfunction

    function automatic t_req_item mk_req(input logic act, input logic [OFF_W-1:0] off,
                                         input logic [SIZE_W-1:0] size,
                                         input logic [FLEN_W-1:0] flen, input logic ferr);
        t_req_item it;
        it.action       = act;
        it.byte_offset  = off;
        it.request_size = size;
        it.fill_length  = flen;
        it.fill_error   = ferr;
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Queues one beat and keeps the planning copy of the cache in step with it.
    task automatic plan_push(input t_req_item it);
        t_page_result r;
        r = cache_step(plan_state, it, page_size_cfg);
        if (r.status == ST_HIT || r.status == ST_FILLED)
            seq_next = r.page_base + r.page_position + r.copy_bytes;
        req_backlog.push_back(it);
    endtask

    // Mostly well-formed traffic: a miss is normally followed by its fill, and
    // lookups favour a few hot regions and sequential reads so that hits occur.
    task automatic plan_traffic(input int count);
        t_req_item   it;
        int          roll;
        int unsigned psz, pos;
        psz = 32'(page_bytes(page_size_cfg));
        for (int n = 0; n < count; n++) begin
            it.action       = ACT_LOOKUP;
            it.byte_offset  = $urandom;
            it.request_size = $urandom;
            it.fill_length  = FLEN_W'($urandom_range(0, 65536));
            it.fill_error   = 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 99);
            if (plan_state.pending) begin
                if (roll >= 8) begin
                    it.action     = ACT_FILL;
                    it.fill_error = ($urandom_range(0, 9) == 0);
                    pos  = plan_state.poff - plan_state.base[plan_state.pslot];
                    roll = $urandom_range(0, 99);
                    if (roll < 40)
                        it.fill_length = FLEN_W'(psz);
                    else if (roll < 70)
                        it.fill_length = FLEN_W'($urandom_range(0, psz));
                    else if (roll < 85)
                        it.fill_length = FLEN_W'($urandom_range(psz, 65536));
                    else
                        it.fill_length = FLEN_W'($urandom_range(0, pos));
                end
            end else if (roll < 6) begin
                it.action = ACT_FILL;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    it.byte_offset = $urandom;
                else if (roll < 45)
                    it.byte_offset = seq_next;
                else
                    it.byte_offset = hot_base[$urandom_range(0, 7)] +
                                     $urandom_range(0, 2) * psz + $urandom_range(0, psz - 1);
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    it.request_size = '0;
                else if (roll < 16)
                    it.request_size = '1;
                else if (roll >= 36)
                    it.request_size = $urandom_range(1, 2 * psz);
            end
            plan_push(it);
        end
        // End on an open miss so the fill straddles the next page size change.
        if (!plan_state.pending)
            plan_push(mk_req(ACT_LOOKUP, $urandom, $urandom, '0, 1'b0));
    endtask

    // Request driver: a beat is held until accepted, then the next is taken.
    always @(posedge i_clk) begin
        logic give;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            give = req_valid;
            if (req_valid && req_if.ready) begin
                predicted_rsp.push_back(cache_step(cache_now, req_item, page_size_cfg));
                accepted_reqs++;
                give = 1'b0;
            end
            if (!give && req_backlog.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                req_item <= req_backlog.pop_front();
                give = 1'b1;
            end
            req_valid <= give;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_page_result want;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_ready) begin
                results_seen++;
                if (predicted_rsp.size() == 0) begin
                    $error("result beat arrived with no result predicted");
                    fail_count++;
                end else begin
                    want = predicted_rsp.pop_front();
                    check_field("status", want.status, rsp_if.status);
                    check_field("slot", want.slot, rsp_if.slot);
                    check_field("page_base", want.page_base, rsp_if.page_base);
                    check_field("page_position", want.page_position, rsp_if.page_position);
                    check_field("copy_bytes", want.copy_bytes, rsp_if.copy_bytes);
                    check_field("final_page", want.final_page, rsp_if.final_page);
                    check_field("beyond_end", want.beyond_end, rsp_if.beyond_end);
                end
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        logic [PSL_W-1:0] seg_psl;
        cache_now     = cache_reset_state();
        page_size_cfg = PSL_RESET;
        seq_next      = '0;
        hot_base[0]   = '0;
        hot_base[1]   = 32'hFFFF_0000;
        for (int k = 2; k < 8; k++)
            hot_base[k] = $urandom & 32'hFFFF_0000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            if (seg < 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 66;
            end else if (seg < 6) begin
                send_idle_pct = 66;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // The first segment runs on the reset page size; the next six walk the extremes,
            // including values outside the legal range, and the last is a random legal value.
            if (seg != 0) begin
                case (seg)
                    1: seg_psl = PSL_MIN;
                    2: seg_psl = PSL_MAX;
                    3: seg_psl = '0;
                    4: seg_psl = '1;
                    5: seg_psl = PSL_MIN - 1'b1;
                    6: seg_psl = PSL_MAX + 1'b1;
                    default: seg_psl = PSL_W'($urandom_range(PSL_MIN, PSL_MAX));
                endcase
                @(posedge i_clk);
                cfg_value <= seg_psl;
                cfg_valid <= 1'b1;
                do @(posedge i_clk); while (!cfg_if.ready);
                cfg_valid <= 1'b0;
                page_size_cfg = seg_psl;
                @(negedge i_clk);
            end
            plan_state = cache_now;
            if (seg == 0) begin
                plan_push(mk_req(ACT_FILL, '0, '0, 17'd4096, 1'b0));
                plan_push(mk_req(ACT_LOOKUP, '0, '0, '0, 1'b0));
                plan_push(mk_req(ACT_LOOKUP, 32'h40, 32'd10, '0, 1'b0));
                plan_push(mk_req(ACT_FILL, '0, '0, 17'd4096, 1'b0));
                plan_push(mk_req(ACT_LOOKUP, 32'd100, '1, '0, 1'b0));
                plan_push(mk_req(ACT_LOOKUP, '1, '1, '0, 1'b0));
                plan_push(mk_req(ACT_FILL, '0, '0, 17'd4096, 1'b1));
                plan_push(mk_req(ACT_LOOKUP, '1, 32'd5, '0, 1'b0));
                plan_push(mk_req(ACT_FILL, '0, '0, 17'd65536, 1'b0));
                plan_push(mk_req(ACT_LOOKUP, 32'hFFFF_F800, '0, '0, 1'b0));
                plan_push(mk_req(ACT_LOOKUP, 32'h2000_0010, 32'd100, '0, 1'b0));
                plan_push(mk_req(ACT_FILL, '0, '0, 17'd8, 1'b0));
                plan_push(mk_req(ACT_LOOKUP, 32'h2000_0004, 32'd100, '0, 1'b0));
                plan_push(mk_req(ACT_LOOKUP, 32'h3000_0000, 32'd1, '0, 1'b0));
                plan_push(mk_req(ACT_FILL, '1, '1, '0, 1'b0));
                plan_push(mk_req(ACT_FILL, '1, '1, 17'd65536, 1'b1));
                plan_push(mk_req(ACT_LOOKUP, 32'h2000_0007, 32'h8000_0000, '0, 1'b0));
            end
            plan_traffic(SEG_ITEMS);
            do @(negedge i_clk);
            while (req_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0);
            repeat (4) @(posedge i_clk);
        end
        $display("Checked %0d results for %0d request beats over %0d page size settings,",
                 results_seen, accepted_reqs, NUM_SEGMENTS);
        $display("covering hits, misses, fills, fill errors and refused beats.");
        if (fail_count == 0) begin
            $display("lru_page_cache_controller test passed");
        end else begin
            $display("lru_page_cache_controller test failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Run did not finish within the time limit.");
        $display("lru_page_cache_controller test failed");
        $finish;
    end

endmodule
